// File: rtl/mfp_pkg.sv
package mfp_pkg;

  // number of motor slots in a frame
  localparam int MOTORS = 4;

  // header, unchecked bytes, eight bytes per motor, then the check byte
  localparam int FRAME_LEN  = 7 + 8 * MOTORS;
  localparam int POS_W      = 7;
  localparam int MIDX_W     = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int CNT_W      = $clog2(MOTORS + 1);
  localparam int CRC_FIRST  = 3;
  localparam int REC_FIRST  = 6;

  localparam logic [15:0] CRC_POLY = 16'h8005;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register map, word index
  localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [1:0] REG_HDR_THIRD  = 2'd2;

  // motor record, byte k of the motor at bits 8k+7..8k
  typedef struct packed {
    logic [15:0] current;
    logic [15:0] speed;
    logic [23:0] position;
    logic [7:0]  mode;
  } rec_t;

  typedef struct packed {
    logic emit;      // valid frame closed by the current word
    logic at_check;  // next word lands on the check byte position
  } parse_stat_t;

  // one byte into CRC-16, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/mfp_parse.sv
module mfp_parse
  import mfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic [7:0]  hdr_first,
  input  logic [7:0]  hdr_second,
  input  logic [7:0]  hdr_third,
  output parse_stat_t stat,
  output rec_t        recs [MOTORS]
);

  localparam logic [POS_W-1:0] P_LEN   = POS_W'(FRAME_LEN);
  localparam logic [POS_W-1:0] P_LAST  = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] P_CRC   = POS_W'(CRC_FIRST);
  localparam logic [POS_W-1:0] P_REC   = POS_W'(REC_FIRST);

  logic [POS_W-1:0]  pos_r, pos_nxt, pos_cur, off;
  logic              bad_r, bad_nxt, bad_cur, live, miss;
  logic [15:0]       crc_r, crc_nxt, crc_cur;
  logic              wr, emit;
  logic [MIDX_W-1:0] wr_m;
  logic [2:0]        wr_lane;
  logic [7:0]        store_r [MOTORS][8];

  // a start word clears the frame before it is counted
  assign pos_cur = frame_start ? '0 : pos_r;
  assign bad_cur = frame_start ? 1'b0 : bad_r;
  assign crc_cur = frame_start ? 16'h0000 : crc_r;
  assign live    = (pos_cur < P_LEN);

  always_comb begin
    priority if (pos_cur == POS_W'(0)) begin
      miss = (rx_byte != hdr_first);
    end else if (pos_cur == POS_W'(1)) begin
      miss = (rx_byte != hdr_second);
    end else if (pos_cur == POS_W'(2)) begin
      miss = (rx_byte != hdr_third);
    end else begin
      miss = 1'b0;
    end
  end

  assign off     = pos_cur - P_REC;
  assign wr_m    = off[3 +: MIDX_W];
  assign wr_lane = off[2:0];
  assign wr      = acc && live && (pos_cur >= P_REC) && (pos_cur < P_LAST);

  always_comb begin
    pos_nxt = pos_r;
    bad_nxt = bad_r;
    crc_nxt = crc_r;
    emit    = 1'b0;
    if (acc) begin
      pos_nxt = pos_cur;
      bad_nxt = bad_cur;
      crc_nxt = crc_cur;
      if (live) begin
        bad_nxt = bad_cur | miss;
        if (pos_cur >= P_CRC && pos_cur < P_LAST) begin
          crc_nxt = crc16_byte(crc_cur, rx_byte);
        end
        emit    = (pos_cur == P_LAST) && !bad_cur && (crc_cur[7:0] == rx_byte);
        pos_nxt = pos_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      bad_r <= 1'b0;
      crc_r <= 16'h0000;
    end else begin
      pos_r <= pos_nxt;
      bad_r <= bad_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      store_r[wr_m][wr_lane] <= rx_byte;
    end
  end

  for (genvar m = 0; m < MOTORS; m++) begin : g_rec
    assign recs[m] = {store_r[m][7], store_r[m][6], store_r[m][5], store_r[m][4],
                      store_r[m][3], store_r[m][2], store_r[m][1], store_r[m][0]};
  end

  assign stat.emit     = emit;
  assign stat.at_check = (pos_r == P_LAST);

endmodule

// File: rtl/motor_feedback_frame_parser.sv
// Motor feedback frame parser.
// Input channel (in_valid / in_stall): one frame word per cycle, in_frame_start
// marks byte 0. A frame is 3 header bytes, 3 unchecked bytes, 8 bytes per
// motor and a check byte. Header bytes are matched against the three
// registers on the APB port (0x0, 0x4, 0x8); the check byte must equal the
// low byte of the CRC-16 (0x8005, init 0) over bytes 3 to the byte before it.
// Output channel (out_valid / out_stall): on a good frame, one record per
// motor in motor order, last_record on the final one; a bad frame gives
// nothing. The first record is valid the cycle after the check word is
// accepted, and the rest follow one per cycle while out_stall is low.
// Throughput: one input word per cycle while in_stall is low. Records are
// copied into an output buffer at the check word, so the next frame streams in
// while they drain. in_stall is high while the byte count sits on the check
// byte and records of the previous frame are still waiting in that buffer;
// it drops once the last of them is taken.
// Reset (rst_n low at a clock edge) clears the registers, the byte count,
// the CRC and the output buffer state; the first word after reset counts as
// byte 0 even without in_frame_start.
module motor_feedback_frame_parser
  import mfp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_rx_byte,
  input  logic                     in_frame_start,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_motor_index,
  output logic [7:0]               out_motor_mode,
  output logic signed [23:0]       out_motor_position,
  output logic signed [15:0]       out_motor_speed,
  output logic signed [15:0]       out_motor_current,
  output logic                     out_last_record,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  logic [7:0]        hdr_first_r, hdr_second_r, hdr_third_r;
  logic              cfg_wr, in_acc, out_take;
  parse_stat_t       stat;
  rec_t              recs [MOTORS];
  rec_t              buf_r [MOTORS];
  rec_t              cur;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MIDX_W-1:0] idx_r, idx_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= 8'h00;
      hdr_second_r <= 8'h00;
      hdr_third_r  <= 8'h00;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HDR_FIRST:  hdr_first_r  <= pwdata[7:0];
        REG_HDR_SECOND: hdr_second_r <= pwdata[7:0];
        REG_HDR_THIRD:  hdr_third_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HDR_FIRST:  prdata = {24'h0, hdr_first_r};
      REG_HDR_SECOND: prdata = {24'h0, hdr_second_r};
      REG_HDR_THIRD:  prdata = {24'h0, hdr_third_r};
      default:        prdata = '0;
    endcase
  end

  // hold the check word while the previous frame's records still drain
  assign in_stall = (cnt_r != '0) && stat.at_check;
  assign in_acc   = in_valid && !in_stall;

  mfp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .hdr_first   (hdr_first_r),
    .hdr_second  (hdr_second_r),
    .hdr_third   (hdr_third_r),
    .stat        (stat),
    .recs        (recs)
  );

  assign out_valid = (cnt_r != '0);
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (stat.emit) begin
      cnt_nxt = CNT_W'(MOTORS);
      idx_nxt = '0;
    end else if (out_take) begin
      cnt_nxt = cnt_r - 1'b1;
      // park on the last record rather than run past the buffer
      if (cnt_r != CNT_W'(1)) begin
        idx_nxt = MIDX_W'(idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      buf_r <= recs;
    end
  end

  assign cur                = buf_r[idx_r];
  assign out_motor_index    = 2'(idx_r);
  assign out_motor_mode     = cur.mode;
  assign out_motor_position = $signed(cur.position);
  assign out_motor_speed    = $signed(cur.speed);
  assign out_motor_current  = $signed(cur.current);
  assign out_last_record    = (cnt_r == CNT_W'(1));

endmodule

// File: rtl/mfp_checker.sv
module mfp_checker
  import mfp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [7:0]          in_rx_byte,
  input logic                in_frame_start,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          out_motor_index,
  input logic [7:0]          out_motor_mode,
  input logic signed [23:0]  out_motor_position,
  input logic signed [15:0]  out_motor_speed,
  input logic signed [15:0]  out_motor_current,
  input logic                out_last_record,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [CFG_AW-1:0]   paddr,
  input logic [CFG_DW-1:0]   pwdata,
  input logic [CFG_DW-1:0]   prdata,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motor_index) &&
      $stable(out_motor_position) && $stable(out_last_record))
    else $error("stalled record changed");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_record |-> out_motor_index == 2'(MOTORS - 1))
    else $error("last record on wrong motor");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_record |=>
      out_valid && out_motor_index == 2'($past(out_motor_index) + 2'd1))
    else $error("records of a frame not contiguous");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("record after reset");

endmodule

bind motor_feedback_frame_parser mfp_checker u_mfp_checker (.*);
